// ===== rtl/ksc_pkg.sv =====
// shared types, constants and helpers for the keyword substitution cipher
package ksc_pkg;

  localparam int LETTERS = 26;
  localparam int IDX_W = $clog2(LETTERS);
  localparam int FILL_W = $clog2(LETTERS + 1);
  localparam logic [7:0] UPPER_BASE = 8'd65;
  localparam logic [7:0] LOWER_BASE = 8'd97;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_END   = 2'd2,
    CMD_MSG   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } letter_t;

  // request to the placement unit
  typedef struct packed {
    logic             clear;
    logic             place;
    logic [IDX_W-1:0] idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } place_req_t;

  function automatic letter_t letter_of(input logic [7:0] c);
    letter_t    r;
    logic [7:0] du;
    logic [7:0] dl;
    du = c - UPPER_BASE;
    dl = c - LOWER_BASE;
    r.hit = 1'b0;
    r.idx = '0;
    if (c >= UPPER_BASE && du < 8'(LETTERS)) begin
      r.hit = 1'b1;
      r.idx = du[IDX_W-1:0];
    end else if (c >= LOWER_BASE && dl < 8'(LETTERS)) begin
      r.hit = 1'b1;
      r.idx = dl[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/keyword_substitution_cipher_core.sv =====
// top level of the keyword substitution cipher core
//
// one command channel: an item is a transfer when start is high and busy
// is low. cmd selects clear, keyword byte, end of keyword or message byte;
// char_in carries the byte.
// clear, keyword byte and message byte leave busy low, so items may
// follow back to back.
// end of keyword starts a walk over the letters A to Z that appends each
// unused one to the alphabet, one letter per cycle through the shared
// placement compare: busy is high for the walk, then the alphabet is
// complete. end of keyword on a complete alphabet does not start the walk.
// a message byte gives one result the cycle after its transfer: strobe is
// high for exactly one cycle with char_out and not_ready. the receiver
// cannot stall, so results are never held back.
// not_ready marks a message byte sent before the alphabet was complete;
// its byte then passes unchanged.
// keyword bytes after completion are ignored until a clear.
// reset clears the used mask, fill count and completion flag and leaves
// the block idle with no result pending.
module keyword_substitution_cipher_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] char_in,
  output logic       strobe,
  output logic [7:0] char_out,
  output logic       not_ready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [ksc_pkg::IDX_W-1:0]   walk;
  logic                        complete;
  logic                        accept;
  ksc_pkg::cmd_t               op;
  ksc_pkg::letter_t            ltr;
  ksc_pkg::place_req_t         req;
  logic [ksc_pkg::IDX_W-1:0]   rd_data;
  logic [7:0]                  out_char;
  logic                        out_sub;

  assign accept = start && !busy;
  assign op = ksc_pkg::cmd_t'(cmd);
  assign ltr = ksc_pkg::letter_of(char_in);
  assign busy = (state == ST_FILL);

  always_comb begin
    req.clear = accept && (op == ksc_pkg::CMD_CLEAR);
    req.rd_en = accept && (op == ksc_pkg::CMD_MSG) && complete && ltr.hit;
    req.rd_idx = ltr.idx;
    if (state == ST_FILL) begin
      req.place = 1'b1;
      req.idx = walk;
    end else begin
      req.place = accept && (op == ksc_pkg::CMD_KEY) && !complete && ltr.hit;
      req.idx = ltr.idx;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == ksc_pkg::CMD_END && !complete) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (walk == ksc_pkg::LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      walk <= '0;
      complete <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= accept && (op == ksc_pkg::CMD_MSG);
      if (state == ST_FILL) begin
        walk <= walk + 1'b1;
        if (walk == ksc_pkg::LAST_IDX) begin
          complete <= 1'b1;
        end
      end else begin
        walk <= '0;
        if (req.clear) begin
          complete <= 1'b0;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && op == ksc_pkg::CMD_MSG) begin
      out_char <= char_in;
      out_sub <= complete && ltr.hit;
      not_ready <= !complete;
    end
  end

  assign char_out = out_sub ? (ksc_pkg::UPPER_BASE + 8'(rd_data)) : out_char;

  ksc_place u_place (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  a_fill_start: assert property (@(posedge clk) disable iff (rst)
    accept && op == ksc_pkg::CMD_END && !complete |=> busy)
    else $error("end of keyword did not start the fill walk");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && op == ksc_pkg::CMD_MSG))
    else $error("result strobe without a message transfer");

  a_busy_incomplete: assert property (@(posedge clk) disable iff (rst)
    busy |-> !complete)
    else $error("fill walk running on a complete alphabet");

  a_complete_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(complete) |-> $past(busy && walk == ksc_pkg::LAST_IDX))
    else $error("alphabet completed outside the end of the fill walk");

endmodule

// ===== rtl/ksc_place.sv =====
// placement unit: used mask, fill count and cipher alphabet memory
module ksc_place (
  input  logic                        clk,
  input  logic                        rst,
  input  ksc_pkg::place_req_t         req,
  output logic [ksc_pkg::IDX_W-1:0]   rd_data
);

  logic [ksc_pkg::LETTERS-1:0] used;
  logic [ksc_pkg::FILL_W-1:0]  fill;
  logic [ksc_pkg::IDX_W-1:0]   alphabet [ksc_pkg::LETTERS];
  logic                        do_place;

  // the one compare that decides whether a letter is appended
  assign do_place = req.place && !used[req.idx] &&
                    (fill < ksc_pkg::FILL_W'(ksc_pkg::LETTERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      fill <= '0;
    end else if (req.clear) begin
      used <= '0;
      fill <= '0;
    end else if (do_place) begin
      used[req.idx] <= 1'b1;
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place && !req.clear) begin
      alphabet[fill[ksc_pkg::IDX_W-1:0]] <= req.idx;
    end
    if (req.rd_en) begin
      rd_data <= alphabet[req.rd_idx];
    end
  end

endmodule
